// ----- hdl/elx_pkg.sv -----
// Shared types, codes and character tables for the expression lexer.
// No dependencies; imported by the scanner, the token queue and the top level.
package elx_pkg;

	// token kinds
	localparam logic [4:0] K_NUMBER = 5'd0;
	localparam logic [4:0] K_IDENT  = 5'd1;
	localparam logic [4:0] K_SIGNAL = 5'd2;
	localparam logic [4:0] K_IF     = 5'd3;
	localparam logic [4:0] K_THEN   = 5'd4;
	localparam logic [4:0] K_ELSE   = 5'd5;
	localparam logic [4:0] K_ASSIGN = 5'd6;
	localparam logic [4:0] K_EQ     = 5'd7;
	localparam logic [4:0] K_NE     = 5'd8;
	localparam logic [4:0] K_GT     = 5'd9;
	localparam logic [4:0] K_GE     = 5'd10;
	localparam logic [4:0] K_LT     = 5'd11;
	localparam logic [4:0] K_LE     = 5'd12;
	localparam logic [4:0] K_AND    = 5'd13;
	localparam logic [4:0] K_OR     = 5'd14;
	localparam logic [4:0] K_PLUS   = 5'd15;
	localparam logic [4:0] K_MINUS  = 5'd16;
	localparam logic [4:0] K_STAR   = 5'd17;
	localparam logic [4:0] K_SLASH  = 5'd18;
	localparam logic [4:0] K_LPAREN = 5'd19;
	localparam logic [4:0] K_RPAREN = 5'd20;
	localparam logic [4:0] K_COMMA  = 5'd21;
	localparam logic [4:0] K_EOF    = 5'd22;
	localparam logic [4:0] K_ERROR  = 5'd23;

	// error codes
	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_BANG    = 3'd1;
	localparam logic [2:0] E_AMP     = 3'd2;
	localparam logic [2:0] E_BAR     = 3'd3;
	localparam logic [2:0] E_BADCHAR = 3'd4;
	localparam logic [2:0] E_DOT     = 3'd5;

	// token queue depth
	localparam int QDEPTH = 4;

	// output tdata width: column, length, error code, padded to bytes
	localparam int TDATA_W = 40;

	// operator that may take a second character
	typedef enum logic [2:0] {
		OP_NONE, OP_EQ, OP_BANG, OP_GT, OP_AMP, OP_BAR, OP_LT
	} op_t;

	// byte classification
	typedef struct packed {
		logic       space;
		logic       digit;
		logic       dot;
		logic       word;    // letter or underscore
		op_t        op;      // first char of a possible two-char operator
		logic       single;  // always a one-char token
		logic [4:0] kind;    // kind of that one-char token
	} cls_t;

	// one result item
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] col;
		logic [15:0] len;
		logic [2:0]  err;
		logic        last;
	} token_t;

	// tokens handed from the scanner to the queue for one accepted item
	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} push_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r = '0;
		r.op = OP_NONE;
		case (c) inside
			[8'h09:8'h0D], 8'h20: r.space = 1'b1;
			[8'h30:8'h39]: r.digit = 1'b1;
			8'h2E: r.dot = 1'b1;
			[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: r.word = 1'b1;
			8'h3D: r.op = OP_EQ;    // =
			8'h21: r.op = OP_BANG;  // !
			8'h3E: r.op = OP_GT;    // >
			8'h26: r.op = OP_AMP;   // &
			8'h7C: r.op = OP_BAR;   // |
			8'h3C: r.op = OP_LT;    // <
			8'h2B: begin r.single = 1'b1; r.kind = K_PLUS; end
			8'h2D: begin r.single = 1'b1; r.kind = K_MINUS; end
			8'h2A: begin r.single = 1'b1; r.kind = K_STAR; end
			8'h2F: begin r.single = 1'b1; r.kind = K_SLASH; end
			8'h28: begin r.single = 1'b1; r.kind = K_LPAREN; end
			8'h29: begin r.single = 1'b1; r.kind = K_RPAREN; end
			8'h2C: begin r.single = 1'b1; r.kind = K_COMMA; end
			default: ;
		endcase
		return r;
	endfunction

	// keyword lengths: signal, if, then, else
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] r;
		unique case (k)
			2'd0: r = 3'd6;
			2'd1: r = 3'd2;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	// keyword characters, valid below kw_len
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
		logic [7:0] r;
		unique case ({k, idx})
			{2'd0, 3'd0}: r = 8'h73; // s
			{2'd0, 3'd1}: r = 8'h69; // i
			{2'd0, 3'd2}: r = 8'h67; // g
			{2'd0, 3'd3}: r = 8'h6E; // n
			{2'd0, 3'd4}: r = 8'h61; // a
			{2'd0, 3'd5}: r = 8'h6C; // l
			{2'd1, 3'd0}: r = 8'h69; // i
			{2'd1, 3'd1}: r = 8'h66; // f
			{2'd2, 3'd0}: r = 8'h74; // t
			{2'd2, 3'd1}: r = 8'h68; // h
			{2'd2, 3'd2}: r = 8'h65; // e
			{2'd2, 3'd3}: r = 8'h6E; // n
			{2'd3, 3'd0}: r = 8'h65; // e
			{2'd3, 3'd1}: r = 8'h6C; // l
			{2'd3, 3'd2}: r = 8'h73; // s
			{2'd3, 3'd3}: r = 8'h65; // e
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// character that completes the two-char form
	function automatic logic [7:0] op_second(input op_t p);
		logic [7:0] r;
		unique case (p)
			OP_AMP: r = 8'h26;
			OP_BAR: r = 8'h7C;
			default: r = 8'h3D;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] op_two(input op_t p);
		logic [4:0] r;
		unique case (p)
			OP_EQ:   r = K_EQ;
			OP_BANG: r = K_NE;
			OP_GT:   r = K_GE;
			OP_AMP:  r = K_AND;
			OP_BAR:  r = K_OR;
			OP_LT:   r = K_LE;
			default: r = K_ERROR;
		endcase
		return r;
	endfunction

	// one-char form; K_ERROR where the operator cannot stand alone
	function automatic logic [4:0] op_one(input op_t p);
		logic [4:0] r;
		unique case (p)
			OP_EQ:   r = K_ASSIGN;
			OP_GT:   r = K_GT;
			OP_LT:   r = K_LT;
			default: r = K_ERROR;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] op_err(input op_t p);
		logic [2:0] r;
		unique case (p)
			OP_BANG: r = E_BANG;
			OP_AMP:  r = E_AMP;
			OP_BAR:  r = E_BAR;
			default: r = E_BADCHAR;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/elx_scan.sv -----
// Front end of the lexer: classifies each accepted byte and runs the scan state.
// Produces zero, one or two tokens per item for the token queue. Uses elx_pkg.
module elx_scan import elx_pkg::*; #(
	parameter int COLUMN_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,       // item accepted this cycle
	input  logic [7:0] char_code,
	input  logic       is_end,
	output push_t      push
);

	typedef enum logic [2:0] {M_IDLE, M_NUM, M_WORD, M_OPER, M_ERR} mode_t;

	mode_t                  mode_q, mode_n;
	logic                   dot_q, dot_n;
	op_t                    pend_q, pend_n;
	logic [3:0]             cand_q, cand_n;
	logic [COLUMN_BITS-1:0] col_q, col_n;
	logic [COLUMN_BITS-1:0] start_q, start_n;
	logic [COLUMN_BITS-1:0] len_q, len_n;

	cls_t       cls;
	token_t     lex_tok, op_tok;
	logic       lex_ok, op_ok, ok;
	logic [4:0] word_kind;
	token_t     toks [2];
	logic [1:0] cnt;
	logic       do_idle;

	function automatic logic [COLUMN_BITS-1:0] sat_inc(input logic [COLUMN_BITS-1:0] v);
		return (&v) ? v : v + COLUMN_BITS'(1);
	endfunction

	// clip a column or length to the 16-bit output field
	function automatic logic [15:0] clip(input logic [COLUMN_BITS-1:0] v);
		logic [COLUMN_BITS+15:0] e;
		e = (COLUMN_BITS+16)'(v);
		if (e > (COLUMN_BITS+16)'(16'hFFFF))
			return 16'hFFFF;
		return e[15:0];
	endfunction

	// drop keyword candidates that no longer match
	function automatic logic [3:0] kw_track(input logic [3:0] cand,
			input logic [COLUMN_BITS-1:0] len, input logic [7:0] c);
		logic [3:0] r;
		r = cand;
		for (int k = 0; k < 4; k++) begin
			if (cand[k] && (len >= COLUMN_BITS'(kw_len(2'(k)))
					|| kw_char(2'(k), len[2:0]) != c))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	assign cls = classify(char_code);

	// kind of a finished word
	always_comb begin
		word_kind = K_IDENT;
		for (int k = 0; k < 4; k++) begin
			if (cand_q[k] && len_q == COLUMN_BITS'(kw_len(2'(k))))
				word_kind = K_SIGNAL + 5'(k);
		end
	end

	// token that closes the pending number or word
	always_comb begin
		lex_ok = 1'b1;
		if (mode_q == M_NUM) begin
			if (dot_q && len_q == COLUMN_BITS'(1)) begin
				lex_ok  = 1'b0;
				lex_tok = '{kind: K_ERROR, col: clip(start_q), len: 16'd1,
					err: E_DOT, last: 1'b0};
			end else begin
				lex_tok = '{kind: K_NUMBER, col: clip(start_q), len: clip(len_q),
					err: E_NONE, last: 1'b0};
			end
		end else begin
			lex_tok = '{kind: word_kind, col: clip(start_q), len: clip(len_q),
				err: E_NONE, last: 1'b0};
		end
	end

	// token for a pending operator not followed by its partner
	always_comb begin
		op_ok = (op_one(pend_q) != K_ERROR);
		if (op_ok)
			op_tok = '{kind: op_one(pend_q), col: clip(start_q), len: 16'd1,
				err: E_NONE, last: 1'b0};
		else
			op_tok = '{kind: K_ERROR, col: clip(start_q), len: 16'd1,
				err: op_err(pend_q), last: 1'b0};
	end

	// next state and emitted tokens for one item
	always_comb begin
		mode_n  = mode_q;
		dot_n   = dot_q;
		pend_n  = pend_q;
		cand_n  = cand_q;
		col_n   = col_q;
		start_n = start_q;
		len_n   = len_q;
		toks[0] = '0;
		toks[1] = '0;
		cnt     = 2'd0;
		do_idle = 1'b0;
		ok      = 1'b1;
		if (is_end) begin
			// close pending token, then end of file unless an error is active or just raised
			unique case (mode_q)
				M_ERR: ok = 1'b0;
				M_NUM, M_WORD: begin
					toks[cnt[0]] = lex_tok;
					cnt = cnt + 2'd1;
					ok = lex_ok;
				end
				M_OPER: begin
					toks[cnt[0]] = op_tok;
					cnt = cnt + 2'd1;
					ok = op_ok;
				end
				default: ;
			endcase
			if (ok) begin
				toks[cnt[0]] = '{kind: K_EOF, col: clip(col_q), len: 16'd0,
					err: E_NONE, last: 1'b0};
				cnt = cnt + 2'd1;
			end
			mode_n  = M_IDLE;
			dot_n   = 1'b0;
			pend_n  = OP_NONE;
			cand_n  = 4'hF;
			col_n   = '0;
			start_n = '0;
			len_n   = '0;
		end else begin
			unique case (mode_q)
				M_ERR: ;
				M_NUM: begin
					if (cls.digit) begin
						len_n = sat_inc(len_q);
					end else if (cls.dot && !dot_q) begin
						dot_n = 1'b1;
						len_n = sat_inc(len_q);
					end else begin
						toks[cnt[0]] = lex_tok;
						cnt = cnt + 2'd1;
						if (!lex_ok) begin
							mode_n = M_ERR;
						end else if (cls.dot) begin
							// second dot opens a new number
							mode_n  = M_NUM;
							dot_n   = 1'b1;
							start_n = col_q;
							len_n   = COLUMN_BITS'(1);
						end else begin
							mode_n  = M_IDLE;
							do_idle = 1'b1;
						end
					end
				end
				M_WORD: begin
					if (cls.word || cls.digit) begin
						cand_n = kw_track(cand_q, len_q, char_code);
						len_n  = sat_inc(len_q);
					end else begin
						toks[cnt[0]] = lex_tok;
						cnt = cnt + 2'd1;
						mode_n  = M_IDLE;
						do_idle = 1'b1;
					end
				end
				M_OPER: begin
					pend_n = OP_NONE;
					if (pend_q != OP_NONE && char_code == op_second(pend_q)) begin
						toks[cnt[0]] = '{kind: op_two(pend_q), col: clip(start_q),
							len: 16'd2, err: E_NONE, last: 1'b0};
						cnt = cnt + 2'd1;
						mode_n = M_IDLE;
					end else begin
						toks[cnt[0]] = op_tok;
						cnt = cnt + 2'd1;
						if (op_ok) begin
							mode_n  = M_IDLE;
							do_idle = 1'b1;
						end else begin
							mode_n = M_ERR;
						end
					end
				end
				default: do_idle = 1'b1;
			endcase

			// byte seen with no token open
			if (do_idle) begin
				if (cls.space) begin
					mode_n = M_IDLE;
				end else if (cls.digit || cls.dot) begin
					mode_n  = M_NUM;
					dot_n   = cls.dot;
					start_n = col_q;
					len_n   = COLUMN_BITS'(1);
				end else if (cls.word) begin
					mode_n  = M_WORD;
					start_n = col_q;
					cand_n  = kw_track(4'hF, '0, char_code);
					len_n   = COLUMN_BITS'(1);
				end else if (cls.op != OP_NONE) begin
					mode_n  = M_OPER;
					pend_n  = cls.op;
					start_n = col_q;
				end else if (cls.single) begin
					toks[cnt[0]] = '{kind: cls.kind, col: clip(col_q), len: 16'd1,
						err: E_NONE, last: 1'b0};
					cnt = cnt + 2'd1;
				end else begin
					toks[cnt[0]] = '{kind: K_ERROR, col: clip(col_q), len: 16'd1,
						err: E_BADCHAR, last: 1'b0};
					cnt = cnt + 2'd1;
					mode_n = M_ERR;
				end
			end
			col_n = sat_inc(col_q);
		end

		// mark the final token of the item
		if (cnt == 2'd1)
			toks[0].last = 1'b1;
		else if (cnt == 2'd2)
			toks[1].last = 1'b1;
	end

	assign push.n  = fire ? cnt : 2'd0;
	assign push.t0 = toks[0];
	assign push.t1 = toks[1];

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			dot_q   <= 1'b0;
			pend_q  <= OP_NONE;
			cand_q  <= 4'hF;
			col_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_n;
			dot_q   <= dot_n;
			pend_q  <= pend_n;
			cand_q  <= cand_n;
			col_q   <= col_n;
			start_q <= start_n;
			len_q   <= len_n;
		end
	end

endmodule

// ----- hdl/elx_queue.sv -----
// Token queue between the scanner and the output port: takes up to two
// tokens a cycle, hands out one. Uses elx_pkg.
module elx_queue import elx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output token_t head,
	output logic   not_empty,
	output logic   has_room    // room for two tokens
);

	localparam int AW = $clog2(QDEPTH);

	token_t        mem_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	// token storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.t0;
		if (push.n == 2'd2)
			mem_q[wr_q + AW'(1)] <= push.t1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.n);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(push.n) - (AW+1)'(pop);
		end
	end

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign has_room  = (cnt_q <= (AW+1)'(QDEPTH - 2));

endmodule

// ----- hdl/expression_lexer.sv -----
// Expression lexer: one source byte per item in, tokens out through the token
// queue. One byte per cycle is taken while the four-token queue has two free
// places; the output port delivers one token per cycle while m_axis_tready is
// high, so a byte that yields two tokens hands them out in turn. arst_n clears
// the scan state and empties the queue.
module expression_lexer import elx_pkg::*; #(
	parameter int COLUMN_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
	input  logic               s_axis_tlast,   // is_end
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [15:0] start_column, [31:16] token_length,
	                                           // [34:32] error_code, rest zero
	output logic [4:0]         m_axis_tuser,   // [4:0] token_kind
	output logic               m_axis_tlast    // last_of_item
);

	push_t  push;
	token_t head;
	logic   not_empty, has_room, fire, pop;

	assign fire = s_axis_tvalid && has_room;
	assign pop  = not_empty && m_axis_tready;

	elx_scan #(
		.COLUMN_BITS(COLUMN_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (s_axis_tdata),
		.is_end    (s_axis_tlast),
		.push      (push)
	);

	elx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.has_room  (has_room)
	);

	// port mapping
	assign s_axis_tready = has_room;
	assign m_axis_tvalid = not_empty;
	assign m_axis_tdata  = {(TDATA_W-35)'(0), head.err, head.len, head.col};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

endmodule
